### design/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types and constants for the remote serial packet receiver: character
// codes, result kinds, reply codes and the classified item passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

    // Default largest payload the design accepts, whatever max_len says.
    localparam int MAX_PACKET_DEF   = 1024;
    // Default depth of the queue between front and back (power of two).
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int LEN_W   = 11;
    localparam int BYTE_W  = 8;

    // Characters of the framing.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BRACE  = 8'h7D;
    localparam logic [7:0] CH_BRK_C  = 8'h03;
    localparam logic [7:0] CH_BRK_D  = 8'h04;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_NO_ACK  = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 11'd1024;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_GOOD    = 3'd1,
        K_BAD     = 3'd2,
        K_BREAK   = 3'd3,
        K_TIMEOUT = 3'd4,
        K_RESTART = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NACK = 2'd2
    } t_reply;

    // One received item after classification.
    typedef struct packed {
        logic             timeout;
        logic [7:0]       ch;
        logic             brk;
        logic             dollar;
        logic             hash;
        logic             brace;
        logic             hex_ok;
        logic [3:0]       hex_val;
    } t_item;

    typedef struct packed {
        logic             no_ack;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

endpackage

`default_nettype wire

### design/rpr_front.sv
// ----------------------------------------------------------------------------
// rpr_front
// Input stage: accepts a transaction, decodes the character (framing marks,
// break characters, hex digit value) and holds it until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_front
    import rpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_full,
    output logic             o_item_valid,
    output t_item            o_item,
    input  wire logic        i_queue_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_accept;
    logic  w_move;

    always_comb begin
        n_item         = '0;
        n_item.timeout = (i_cmd == CMD_TIMEOUT);
        n_item.ch      = i_rx_byte;
        n_item.brk     = (i_rx_byte == CH_BRK_C) || (i_rx_byte == CH_BRK_D);
        n_item.dollar  = (i_rx_byte == CH_DOLLAR);
        n_item.hash    = (i_rx_byte == CH_HASH);
        n_item.brace   = (i_rx_byte == CH_BRACE);
        if (i_rx_byte >= 8'h30 && i_rx_byte <= 8'h39) begin
            n_item.hex_ok  = 1'b1;
            n_item.hex_val = 4'(i_rx_byte - 8'h30);
        end else if (i_rx_byte >= 8'h61 && i_rx_byte <= 8'h66) begin
            n_item.hex_ok  = 1'b1;
            n_item.hex_val = 4'(i_rx_byte - 8'h57);
        end else if (i_rx_byte >= 8'h41 && i_rx_byte <= 8'h46) begin
            n_item.hex_ok  = 1'b1;
            n_item.hex_val = 4'(i_rx_byte - 8'h37);
        end
    end

    assign w_move       = r_valid && !i_queue_full;
    assign o_full       = r_valid && i_queue_full;
    assign w_accept     = i_push && !o_full;
    assign o_item_valid = w_move;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_move) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### design/rpr_queue.sv
// ----------------------------------------------------------------------------
// rpr_queue
// Short queue of classified items between the front and back ends.
// DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_queue
    import rpr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_item       o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= PW'(r_wr_ptr + 1'b1);
            end
            if (w_rd) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            if (w_wr && !w_rd) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (w_rd && !w_wr) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // The front end must never offer an item while the queue is full.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

### design/rpr_back.sv
// ----------------------------------------------------------------------------
// rpr_back
// Packet framing state machine: tracks the packet phase, payload length and
// running checksum, and loads at most one result per item into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_back
    import rpr_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_item_valid,
    input  wire t_item             i_item,
    output logic                   o_item_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_data,
    output logic [LEN_W-1:0]       o_length,
    output logic [1:0]             o_reply
);

    // max_len never exceeds 2047, so a larger cap never limits.
    localparam logic [LEN_W-1:0] CAP =
        (MAX_PACKET > 2047) ? 11'd2047 : LEN_W'(MAX_PACKET);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAYLOAD,
        S_ESCAPE,
        S_CSUM1,
        S_CSUM2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [7:0]        r_sum, n_sum;
    logic [4:0]        r_first, n_first;

    logic              r_out_valid;
    t_kind             r_kind;
    logic [7:0]        r_data;
    logic [LEN_W-1:0]  r_length;
    t_reply            r_reply;

    logic              w_take;
    logic              w_emit;
    t_kind             w_kind;
    logic [7:0]        w_data;
    logic [LEN_W-1:0]  w_length;
    t_reply            w_reply;
    logic [LEN_W-1:0]  w_limit;
    logic [7:0]        w_value;

    assign w_limit    = (i_cfg.max_len < CAP) ? i_cfg.max_len : CAP;
    assign w_take     = i_item_valid && (!r_out_valid || i_pop);
    assign o_item_pop = w_take;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_first  = r_first;
        w_emit   = 1'b0;
        w_kind   = K_BYTE;
        w_data   = '0;
        w_length = '0;
        w_reply  = RPL_NONE;
        w_value  = '0;
        if (r_first[4]) begin
            w_value = i_item.hex_ok ? {r_first[3:0], i_item.hex_val}
                                    : {4'h0, r_first[3:0]};
        end
        if (i_item.timeout) begin
            if (r_phase == S_IDLE) begin
                w_emit = 1'b1;
                w_kind = K_TIMEOUT;
            end
        end else begin
            case (r_phase)
                S_IDLE: begin
                    if (i_item.brk) begin
                        w_emit = 1'b1;
                        w_kind = K_BREAK;
                        w_data = i_item.ch;
                    end else if (i_item.dollar) begin
                        n_phase = S_PAYLOAD;
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
                S_PAYLOAD: begin
                    if (i_item.hash || r_count >= w_limit) begin
                        n_phase = S_CSUM1;
                    end else if (i_item.dollar) begin
                        n_count  = '0;
                        n_sum    = '0;
                        w_emit   = 1'b1;
                        w_kind   = K_RESTART;
                        w_length = r_count;
                    end else if (i_item.brace) begin
                        n_phase = S_ESCAPE;
                    end else begin
                        n_sum   = 8'(r_sum + i_item.ch);
                        n_count = LEN_W'(r_count + 1'b1);
                        w_emit  = 1'b1;
                        w_kind  = K_BYTE;
                        w_data  = i_item.ch;
                    end
                end
                S_ESCAPE: begin
                    n_sum   = 8'(r_sum + i_item.ch + CH_BRACE);
                    n_count = LEN_W'(r_count + 1'b1);
                    n_phase = S_PAYLOAD;
                    w_emit  = 1'b1;
                    w_kind  = K_BYTE;
                    w_data  = i_item.ch ^ ESC_XOR;
                end
                S_CSUM1: begin
                    n_first = i_item.hex_ok ? {1'b1, i_item.hex_val} : 5'd0;
                    n_phase = S_CSUM2;
                end
                S_CSUM2: begin
                    n_phase  = S_IDLE;
                    n_first  = '0;
                    w_emit   = 1'b1;
                    w_length = r_count;
                    if (w_value == r_sum) begin
                        w_kind  = K_GOOD;
                        w_reply = i_cfg.no_ack ? RPL_NONE : RPL_ACK;
                    end else begin
                        w_kind  = K_BAD;
                        w_reply = i_cfg.no_ack ? RPL_NONE : RPL_NACK;
                    end
                end
                default: begin
                    n_phase = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_sum   <= n_sum;
                r_first <= n_first;
            end
            if (w_take && w_emit) begin
                r_out_valid <= 1'b1;
                r_kind      <= w_kind;
                r_data      <= w_data;
                r_length    <= w_length;
                r_reply     <= w_reply;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_kind   = r_kind;
    assign o_data   = r_data;
    assign o_length = r_length;
    assign o_reply  = r_reply;

    a_first_only_in_csum2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first[4] |-> (r_phase == S_CSUM2))
        else $error("checksum digit held outside second digit phase");

    a_reply_only_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_reply != RPL_NONE) |-> (r_kind == K_GOOD || r_kind == K_BAD))
        else $error("reply requested for a non-verdict result");

    a_verdict_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_item.timeout && r_phase == S_CSUM2)
            |=> (r_phase == S_IDLE && r_out_valid))
        else $error("second checksum digit did not produce a verdict");

endmodule

`default_nettype wire

### design/rsp_packet_receiver.sv
// ----------------------------------------------------------------------------
// rsp_packet_receiver
// Byte-wise receiver for remote serial debug packets: frames '$'...'#xx'
// packets, unescapes payload bytes, checks the checksum and reports break
// characters, timeouts and restarts.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   --------------------------------------
//  input     i_push / o_full           i_cmd, i_rx_byte
//  result    o_empty / i_pop           o_kind, o_data, o_length, o_reply
//  config    i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
// One transaction per clock is sustained in both directions while results are
// popped and the queue does not fill; the framing state machine updates its
// state once per item taken. When nothing stalls, an accepted input is loaded
// into the front register, moves on into the queue, and its result is loaded
// into the result register, which drives the result ports.
// Reset is synchronous and active low; it returns the framing to idle, empties
// the queue and result register, and loads the register defaults (acks on,
// max_len 1024). A result that is not popped holds the back end, which keeps
// consuming nothing; the front end and queue keep accepting until the queue
// fills, and only then is o_full raised.
//
`default_nettype none

module rsp_packet_receiver
    import rpr_pkg::*;
#(
    parameter int MAX_PACKET  = MAX_PACKET_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic              i_cmd,
    input  wire logic [7:0]        i_rx_byte,
    // results
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_data,
    output logic [LEN_W-1:0]       o_length,
    output logic [1:0]             o_reply,
    // configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata
);

    // Configuration registers. The user must write them only while the block is
    // idle; the block does not enforce it, and the back end reads them directly.
    t_cfg  r_cfg;

    t_item w_front_item;
    logic  w_front_valid;
    logic  w_queue_full;
    t_item w_queue_item;
    logic  w_queue_valid;
    logic  w_queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.no_ack  <= 1'b0;
            r_cfg.max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NO_ACK:  r_cfg.no_ack  <= i_cfg_wdata[0];
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_wdata;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // Front end: takes the transaction and decodes the character.
    rpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .o_full       (o_full),
        .o_item_valid (w_front_valid),
        .o_item       (w_front_item),
        .i_queue_full (w_queue_full)
    );

    // Decoupling queue so the two ends stall independently.
    rpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_item),
        .o_full  (w_queue_full),
        .i_pop   (w_queue_pop),
        .o_valid (w_queue_valid),
        .o_item  (w_queue_item)
    );

    // Back end: framing state machine and result register.
    rpr_back #(
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_queue_valid),
        .i_item       (w_queue_item),
        .o_item_pop   (w_queue_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_length     (o_length),
        .o_reply      (o_reply)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remote serial packet receiver. Byte and timeout
// transactions go in through the push/full side; every accepted transaction
// runs through a bench-side framing predictor, and the results it produces are
// queued and compared field by field with what the block hands out on the
// empty/pop side. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rpr_pkg::*;

    // Cycles to wait after the last expected result before a register write
    // or the end of the run. Items without a result may still be travelling
    // through the front register, the queue and the result register.
    localparam int DRAIN_CYCLES = 12;
    // Cycles without any transaction on either side before the run is abandoned.
    localparam int WDOG_LIMIT   = 2000;
    // Roughly how many effective input transactions the random part sends.
    localparam int RANDOM_ITEMS = 1750;
    // Only the first mismatches are printed; all of them are counted.
    localparam int MAX_REPORTS  = 40;

    // Framing phases as the predictor tracks them.
    typedef enum logic [2:0] {
        FR_HUNT,
        FR_BODY,
        FR_ESC,
        FR_SUM_HI,
        FR_SUM_LO
    } t_frame;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
        t_reply           reply;
    } t_result;

    // One row of the directed table: either an input transaction or a register
    // write. For register writes, sel is the register index; for items, the
    // command. Rows marked typed carry their expected result directly.
    typedef struct packed {
        logic             is_cfg;
        logic             sel;
        logic [7:0]       ch;
        logic [LEN_W-1:0] cfg_val;
        logic             typed;
        t_result          want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_push;
    logic             o_full;
    logic             i_cmd;
    logic [7:0]       i_rx_byte;
    logic             o_empty;
    logic             i_pop;
    logic [2:0]       o_kind;
    logic [7:0]       o_data;
    logic [LEN_W-1:0] o_length;
    logic [1:0]       o_reply;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [LEN_W-1:0] i_cfg_wdata;

    // Predictor state and its copy of the configuration registers.
    t_frame           fr_phase;
    logic [LEN_W-1:0] fr_count;
    logic [7:0]       fr_sum;
    logic             fr_hi_ok;
    logic [3:0]       fr_hi_val;
    logic             cfg_no_ack;
    logic [LEN_W-1:0] cfg_max_len;

    // Results predicted but not yet handed out by the block, oldest first.
    t_result          pending_results[$];
    int               err_count;
    int               items_sent;
    bit               last_got;
    bit               idling_on;

    rsp_packet_receiver #(
        .MAX_PACKET  (MAX_PACKET_DEF),
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_length    (o_length),
        .o_reply     (o_reply),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // Idle length for either side. Most gaps are short, a few are long, and in
    // phases with idling switched off both sides run back to back.
    function automatic int pick_gap();
        int r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Hex digit decode; both cases of the letters count as digits.
    function automatic bit decode_hex(input logic [7:0] ch, output logic [3:0] val);
        val = 4'h0;
        if (ch >= "0" && ch <= "9") begin
            val = ch[3:0];
            return 1'b1;
        end
        if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
            val = ch[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] val, input bit upper);
        if (val < 4'd10) return {4'h3, val};
        return (upper ? 8'h40 : 8'h60) + {4'h0, val - 4'd9};
    endfunction

    // The payload limit in force: max_len, capped at the largest packet size.
    function automatic int active_limit();
        return (cfg_max_len < MAX_PACKET_DEF) ? int'(cfg_max_len) : MAX_PACKET_DEF;
    endfunction

    // Advances the framing predictor by one accepted transaction. Returns 1 and
    // fills res when the transaction produces a result.
    function automatic bit rx_frame_step(input logic cmd, input logic [7:0] ch,
                                         output t_result res);
        int         limit;
        logic [3:0] lo_val;
        logic       lo_ok;
        logic [7:0] csum;
        res = '0;
        limit = active_limit();
        // A timeout tick only means something while hunting for a packet.
        if (cmd == CMD_TIMEOUT) begin
            if (fr_phase != FR_HUNT) return 1'b0;
            res.kind = K_TIMEOUT;
            return 1'b1;
        end
        case (fr_phase)
            FR_HUNT: begin
                if (ch == CH_BRK_C || ch == CH_BRK_D) begin
                    res.kind = K_BREAK;
                    res.data = ch;
                    return 1'b1;
                end
                if (ch == CH_DOLLAR) begin
                    fr_phase = FR_BODY;
                    fr_count = '0;
                    fr_sum   = 8'h00;
                end
                return 1'b0;
            end
            FR_BODY: begin
                // The terminator, or any byte once the payload is full, moves
                // on to the checksum digits; a byte at the limit is dropped.
                if (ch == CH_HASH || int'(fr_count) >= limit) begin
                    fr_phase = FR_SUM_HI;
                    return 1'b0;
                end
                if (ch == CH_DOLLAR) begin
                    res.kind   = K_RESTART;
                    res.length = fr_count;
                    fr_count   = '0;
                    fr_sum     = 8'h00;
                    return 1'b1;
                end
                if (ch == CH_BRACE) begin
                    fr_phase = FR_ESC;
                    return 1'b0;
                end
                fr_sum   = fr_sum + ch;
                fr_count = fr_count + 1'b1;
                res.kind = K_BYTE;
                res.data = ch;
                return 1'b1;
            end
            FR_ESC: begin
                // The escape character itself is part of the checksum.
                fr_sum   = fr_sum + ch + CH_BRACE;
                fr_count = fr_count + 1'b1;
                fr_phase = FR_BODY;
                res.kind = K_BYTE;
                res.data = ch ^ ESC_XOR;
                return 1'b1;
            end
            FR_SUM_HI: begin
                fr_hi_ok = decode_hex(ch, fr_hi_val);
                fr_phase = FR_SUM_LO;
                return 1'b0;
            end
            FR_SUM_LO: begin
                // A non-hex digit ends the number where it stands.
                lo_ok = decode_hex(ch, lo_val);
                csum  = 8'h00;
                if (fr_hi_ok) begin
                    csum = lo_ok ? {fr_hi_val, lo_val} : {4'h0, fr_hi_val};
                end
                fr_phase   = FR_HUNT;
                fr_hi_ok   = 1'b0;
                fr_hi_val  = 4'h0;
                res.length = fr_count;
                if (csum == fr_sum) begin
                    res.kind  = K_GOOD;
                    res.reply = cfg_no_ack ? RPL_NONE : RPL_ACK;
                end else begin
                    res.kind  = K_BAD;
                    res.reply = cfg_no_ack ? RPL_NONE : RPL_NACK;
                end
                return 1'b1;
            end
            default: begin
                fr_phase = FR_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // Sends one input transaction after a random gap, waits until the block
    // takes it, then runs it through the predictor. Transactions the block
    // simply ignores are not counted toward the stimulus volume.
    task automatic push_item(input logic cmd, input logic [7:0] ch);
        int      gap;
        t_result res;
        t_frame  prior;
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_cmd     <= cmd;
        i_rx_byte <= ch;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        prior    = fr_phase;
        last_got = rx_frame_step(cmd, ch, res);
        if (last_got) pending_results.push_back(res);
        if (last_got || !((cmd == CMD_TIMEOUT && prior != FR_HUNT) ||
                          (prior == FR_HUNT && fr_phase == FR_HUNT))) begin
            items_sent++;
        end
    endtask

    // Stops sending and waits until the block has nothing left in flight.
    task automatic settle();
        i_push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the enable drops for a cycle so that back-to-back
    // writes never lower and raise it in the same step.
    task automatic write_cfg(input logic idx, input logic [LEN_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NO_ACK) begin
            cfg_no_ack = val[0];
        end else begin
            cfg_max_len = val;
        end
        @(posedge i_clk);
    endtask

    // One packet with random payload. Payload bytes that collide with the
    // framing characters, and some others, go out escaped. A broken packet has
    // one fault: a restart in the middle, no terminator at all, a wrong
    // checksum, or a non-hex checksum digit. The checksum comes from the
    // predictor's running sum, so a packet cut short by the limit still checks.
    task automatic send_packet(input int len, input bit broken);
        int          i;
        int          fault;
        logic [31:0] rnd;
        logic [31:0] junk;
        logic [7:0]  csum;
        logic [3:0]  v;
        bit          upper;
        fault = broken ? $urandom_range(1, 4) : 0;
        push_item(CMD_BYTE, CH_DOLLAR);
        for (i = 0; i < len && fr_phase == FR_BODY; i++) begin
            rnd = $urandom;
            if (rnd[31:27] == 5'd0) push_item(CMD_TIMEOUT, rnd[15:8]);
            if (fault == 1 && i == len / 2) push_item(CMD_BYTE, CH_DOLLAR);
            if (rnd[7:0] == CH_DOLLAR || rnd[7:0] == CH_HASH ||
                rnd[7:0] == CH_BRACE || rnd[26:24] == 3'd0) begin
                push_item(CMD_BYTE, CH_BRACE);
                if (fr_phase == FR_ESC) push_item(CMD_BYTE, rnd[7:0] ^ ESC_XOR);
            end else begin
                push_item(CMD_BYTE, rnd[7:0]);
            end
        end
        // An abandoned packet is left open; the next start character restarts it.
        if (fault != 2) begin
            if (fr_phase == FR_BODY) push_item(CMD_BYTE, CH_HASH);
            if (fr_phase == FR_SUM_HI) begin
                csum = fr_sum;
                if (fault == 3) csum = csum ^ (8'h01 << $urandom_range(0, 7));
                upper = $urandom_range(0, 1);
                do junk = $urandom; while (decode_hex(junk[7:0], v));
                if (fault == 4 && junk[8]) begin
                    push_item(CMD_BYTE, junk[7:0]);
                end else begin
                    push_item(CMD_BYTE, hex_char(csum[7:4], upper));
                end
                if (fault == 4 && !junk[8]) begin
                    push_item(CMD_BYTE, junk[7:0]);
                end else begin
                    push_item(CMD_BYTE, hex_char(csum[3:0], upper));
                end
            end
        end
    endtask

    function automatic t_row item_row(input logic cmd, input logic [7:0] ch);
        t_row row;
        row     = '0;
        row.sel = cmd;
        row.ch  = ch;
        return row;
    endfunction

    function automatic t_row known_row(input logic cmd, input logic [7:0] ch,
                                       input t_kind kind, input logic [7:0] data,
                                       input logic [LEN_W-1:0] len, input t_reply reply);
        t_row row;
        row             = item_row(cmd, ch);
        row.typed       = 1'b1;
        row.want.kind   = kind;
        row.want.data   = data;
        row.want.length = len;
        row.want.reply  = reply;
        return row;
    endfunction

    function automatic t_row reg_row(input logic idx, input logic [LEN_W-1:0] val);
        t_row row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.sel     = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // Result side: pops with random stalls and compares every result
    // transaction with the oldest prediction.
    initial begin : result_sink
        int      hold;
        t_result want;
        i_pop <= 1'b0;
        hold = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (i_pop && !o_empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: kind %0d data %02h length %0d reply %0d",
                        o_kind, o_data, o_length, o_reply));
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  o_kind, want.kind));
                    end
                    if (o_data !== want.data) begin
                        report_mismatch($sformatf("data %02h, expected %02h (kind %0d)",
                                                  o_data, want.data, want.kind));
                    end
                    if (o_length !== want.length) begin
                        report_mismatch($sformatf("length %0d, expected %0d (kind %0d)",
                                                  o_length, want.length, want.kind));
                    end
                    if (o_reply !== want.reply) begin
                        report_mismatch($sformatf("reply %0d, expected %0d (kind %0d)",
                                                  o_reply, want.reply, want.kind));
                    end
                end
            end
            if (hold == 0) begin
                hold = pick_gap();
            end else begin
                hold--;
            end
            i_pop <= (hold == 0);
            @(posedge i_clk);
        end
    end

    // Ends the run if neither side completes a transaction for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("rsp_packet_receiver: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_row             dir_rows[$];
        t_row             row;
        int               p;
        int               stop_at;
        int               len;
        int               pick;
        logic [31:0]      rnd;
        logic [LEN_W-1:0] ml;
        logic             na;

        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_cmd       <= CMD_BYTE;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_NO_ACK;
        i_cfg_wdata <= '0;

        // Predictor and register copy start from the reset state.
        fr_phase    = FR_HUNT;
        fr_count    = '0;
        fr_sum      = 8'h00;
        fr_hi_ok    = 1'b0;
        fr_hi_val   = 4'h0;
        cfg_no_ack  = 1'b0;
        cfg_max_len = MAX_LEN_RST;
        err_count   = 0;
        items_sent  = 0;
        idling_on   = 1'b1;

        // Directed table, run with the reset configuration first.
        // Idle: timeout tick, both break characters, a dropped 0xFF.
        dir_rows.push_back(known_row(CMD_TIMEOUT, 8'h00, K_TIMEOUT, 8'h00, 11'd0, RPL_NONE));
        dir_rows.push_back(known_row(CMD_BYTE, CH_BRK_C, K_BREAK, CH_BRK_C, 11'd0, RPL_NONE));
        dir_rows.push_back(known_row(CMD_BYTE, CH_BRK_D, K_BREAK, CH_BRK_D, 11'd0, RPL_NONE));
        dir_rows.push_back(item_row(CMD_BYTE, 8'hFF));
        // Payload extremes, a timeout inside the packet, then a restart.
        dir_rows.push_back(item_row(CMD_BYTE, CH_DOLLAR));
        dir_rows.push_back(item_row(CMD_BYTE, 8'h00));
        dir_rows.push_back(item_row(CMD_TIMEOUT, 8'hFF));
        dir_rows.push_back(item_row(CMD_BYTE, 8'hFF));
        dir_rows.push_back(known_row(CMD_BYTE, CH_DOLLAR, K_RESTART, 8'h00, 11'd2, RPL_NONE));
        // Escaped terminator and escaped start character, then a good checksum.
        dir_rows.push_back(item_row(CMD_BYTE, CH_BRACE));
        dir_rows.push_back(item_row(CMD_BYTE, CH_HASH));
        dir_rows.push_back(item_row(CMD_BYTE, CH_BRACE));
        dir_rows.push_back(item_row(CMD_BYTE, CH_DOLLAR));
        dir_rows.push_back(item_row(CMD_BYTE, CH_HASH));
        dir_rows.push_back(item_row(CMD_BYTE, "4"));
        dir_rows.push_back(item_row(CMD_BYTE, "1"));
        // Non-hex first checksum digit: the value is zero, so this one fails.
        dir_rows.push_back(item_row(CMD_BYTE, CH_DOLLAR));
        dir_rows.push_back(item_row(CMD_BYTE, "a"));
        dir_rows.push_back(item_row(CMD_BYTE, CH_HASH));
        dir_rows.push_back(item_row(CMD_BYTE, "x"));
        dir_rows.push_back(known_row(CMD_BYTE, "6", K_BAD, 8'h00, 11'd1, RPL_NACK));
        // Limit zero: the first payload byte ends the payload. The non-hex
        // second digit leaves the first digit's value, zero, matching the sum.
        dir_rows.push_back(reg_row(CFG_MAX_LEN, 11'd0));
        dir_rows.push_back(item_row(CMD_BYTE, CH_DOLLAR));
        dir_rows.push_back(item_row(CMD_BYTE, "A"));
        dir_rows.push_back(item_row(CMD_BYTE, "0"));
        dir_rows.push_back(known_row(CMD_BYTE, "g", K_GOOD, 8'h00, 11'd0, RPL_ACK));
        // Payload full at one byte with replies suppressed.
        dir_rows.push_back(reg_row(CFG_NO_ACK, 11'd1));
        dir_rows.push_back(reg_row(CFG_MAX_LEN, 11'd1));
        dir_rows.push_back(item_row(CMD_BYTE, CH_DOLLAR));
        dir_rows.push_back(item_row(CMD_BYTE, "Q"));
        dir_rows.push_back(item_row(CMD_BYTE, "R"));
        dir_rows.push_back(item_row(CMD_BYTE, "5"));
        dir_rows.push_back(known_row(CMD_BYTE, "1", K_GOOD, 8'h00, 11'd1, RPL_NONE));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                settle();
                write_cfg(row.sel, row.cfg_val);
            end else begin
                push_item(row.sel, row.ch);
                // A typed row replaces the predicted result with the one
                // written into the table.
                if (row.typed) begin
                    if (last_got) begin
                        pending_results[pending_results.size() - 1] = row.want;
                    end else begin
                        pending_results.push_back(row.want);
                    end
                end
            end
        end

        // Random part, in phases. Each phase starts from a drained block, which
        // may still be in the middle of a packet, and rewrites both registers.
        items_sent = 0;
        p = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            rnd = $urandom;
            na  = rnd[0];
            case (p % 6)
                0: begin
                    ml = MAX_LEN_RST;
                    na = 1'b0;
                end
                1: begin
                    ml = 11'd1;
                    na = 1'b1;
                end
                2: begin
                    rnd = $urandom_range(2, 16);
                    ml  = rnd[LEN_W-1:0];
                end
                3: ml = 11'h7FF;
                4: begin
                    rnd = $urandom_range(0, MAX_PACKET_DEF);
                    ml  = rnd[LEN_W-1:0];
                end
                default: begin
                    ml = 11'd0;
                    na = 1'b0;
                end
            endcase
            write_cfg(CFG_NO_ACK, {{(LEN_W-1){1'b0}}, na});
            write_cfg(CFG_MAX_LEN, ml);
            idling_on = ($urandom_range(0, 3) != 0);

            // Once, a packet long enough to fill the largest payload.
            if (p == 0) send_packet(MAX_PACKET_DEF + 6, 1'b0);

            stop_at = items_sent + $urandom_range(100, 220);
            while (items_sent < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    len = $urandom_range(0, 6);
                end else if (pick < 85) begin
                    len = $urandom_range(7, 24);
                end else if (active_limit() <= 64) begin
                    len = (active_limit() > 0 ? active_limit() - 1 : 0) + $urandom_range(0, 3);
                end else begin
                    len = $urandom_range(25, 70);
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    send_packet(len, 1'b0);
                end else if (pick < 88) begin
                    send_packet(len, 1'b1);
                end else begin
                    // Line noise: timeouts, break characters and stray bytes.
                    rnd = $urandom;
                    case (rnd[10:8])
                        3'd0, 3'd1: push_item(CMD_TIMEOUT, rnd[7:0]);
                        3'd2: push_item(CMD_BYTE, rnd[11] ? CH_BRK_C : CH_BRK_D);
                        3'd3: push_item(CMD_BYTE, 8'hFF);
                        default: push_item(CMD_BYTE, rnd[7:0]);
                    endcase
                end
            end
            p++;
        end

        settle();
        if (err_count == 0) begin
            $display("rsp_packet_receiver: match");
        end else begin
            $display("rsp_packet_receiver: mismatch");
        end
        $finish;
    end

endmodule
